// ----- design/pidpi_pkg.sv -----
// ----------------------------------------------------------------------------
// pidpi_pkg
// Shared types and constants of the PID controller: config layout, register
// indexes, reset values and the result word.
// ----------------------------------------------------------------------------
package pidpi_pkg;

    localparam int GAIN_W     = 16;  // signed gain width
    localparam int LIM_W      = 21;  // signed integral limit width
    localparam int DRIVE_W    = 28;  // signed drive width
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = LIM_W;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE,
        CFG_KP,
        CFG_KI,
        CFG_KD,
        CFG_INTEGRAL_HIGH,
        CFG_INTEGRAL_LOW
    } cfg_addr_t;

    localparam logic                    MODE_RESET          = MODE_POSITIONAL;
    localparam logic signed [GAIN_W-1:0] KP_RESET           = -16'sd5376;
    localparam logic signed [GAIN_W-1:0] KI_RESET           = -16'sd333;
    localparam logic signed [GAIN_W-1:0] KD_RESET           = -16'sd21299;
    localparam logic signed [LIM_W-1:0]  INTEGRAL_HIGH_RESET = 21'sd1000;
    localparam logic signed [LIM_W-1:0]  INTEGRAL_LOW_RESET  = -21'sd500;

    typedef struct packed {
        logic                     mode;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic signed [LIM_W-1:0]  integral_high;
        logic signed [LIM_W-1:0]  integral_low;
    } cfg_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      integral_limited;
    } result_t;

endpackage

// ----- design/pidpi_cfg.sv -----
// ----------------------------------------------------------------------------
// pidpi_cfg
// Configuration register file: write-only, one register per index.
// ----------------------------------------------------------------------------
module pidpi_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pidpi_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pidpi_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output pidpi_pkg::cfg_t                      cfg
);

    pidpi_pkg::cfg_t cfg_reg;
    pidpi_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (pidpi_pkg::cfg_addr_t'(cfg_addr))
                pidpi_pkg::CFG_MODE: begin
                    cfg_next.mode = cfg_wdata[0];
                end
                pidpi_pkg::CFG_KP: begin
                    cfg_next.kp = cfg_wdata[pidpi_pkg::GAIN_W-1:0];
                end
                pidpi_pkg::CFG_KI: begin
                    cfg_next.ki = cfg_wdata[pidpi_pkg::GAIN_W-1:0];
                end
                pidpi_pkg::CFG_KD: begin
                    cfg_next.kd = cfg_wdata[pidpi_pkg::GAIN_W-1:0];
                end
                pidpi_pkg::CFG_INTEGRAL_HIGH: begin
                    cfg_next.integral_high = cfg_wdata[pidpi_pkg::LIM_W-1:0];
                end
                pidpi_pkg::CFG_INTEGRAL_LOW: begin
                    cfg_next.integral_low = cfg_wdata[pidpi_pkg::LIM_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;  // unused index, ignored
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode          <= pidpi_pkg::MODE_RESET;
            cfg_reg.kp            <= pidpi_pkg::KP_RESET;
            cfg_reg.ki            <= pidpi_pkg::KI_RESET;
            cfg_reg.kd            <= pidpi_pkg::KD_RESET;
            cfg_reg.integral_high <= pidpi_pkg::INTEGRAL_HIGH_RESET;
            cfg_reg.integral_low  <= pidpi_pkg::INTEGRAL_LOW_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/pidpi_datapath.sv -----
// ----------------------------------------------------------------------------
// pidpi_datapath
// One-pass PID arithmetic plus error history and integral state. State moves
// on when upd is high.
// ----------------------------------------------------------------------------
module pidpi_datapath #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           upd,
    input  logic signed [SAMPLE_WIDTH-1:0] measured,
    input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
    input  pidpi_pkg::cfg_t                cfg,
    output pidpi_pkg::result_t             result
);

    localparam int GW    = pidpi_pkg::GAIN_W;
    localparam int DW    = pidpi_pkg::DRIVE_W;
    localparam int ERR_W = SAMPLE_WIDTH + 1;
    localparam int INT_W = pidpi_pkg::LIM_W + GAIN_FRAC_BITS;
    // wide enough for every partial sum in either mode, plus saturation headroom
    localparam int A0    = (SAMPLE_WIDTH + 20 > GAIN_FRAC_BITS + 23) ?
                           SAMPLE_WIDTH + 20 : GAIN_FRAC_BITS + 23;
    localparam int ACC_W = (A0 > DW + 2) ? A0 : DW + 2;

    logic signed [ERR_W-1:0] last_err_reg;
    logic signed [ERR_W-1:0] older_err_reg;
    logic signed [INT_W-1:0] integral_reg;

    logic signed [ERR_W-1:0]        err;
    logic signed [ERR_W:0]          de;
    logic signed [ERR_W:0]          de1;
    logic signed [ERR_W+1:0]        dd;
    logic signed [ERR_W+1:0]        kp_op;
    logic signed [ERR_W+1:0]        kd_op;
    logic signed [GW+ERR_W+1:0]     kp_prod;
    logic signed [GW+ERR_W-1:0]     ki_prod;
    logic signed [GW+ERR_W+1:0]     kd_prod;
    logic signed [ACC_W-1:0]        top;
    logic signed [ACC_W-1:0]        bot;
    logic signed [ACC_W-1:0]        int_pre;
    logic signed [ACC_W-1:0]        int_hi_clamped;
    logic signed [ACC_W-1:0]        int_clamped;
    logic                           over_top;
    logic                           under_bot;
    logic signed [ACC_W-1:0]        third_term;
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        shifted;
    logic                           pos_ovf;
    logic                           neg_ovf;
    logic                           positional;

    always_comb begin
        positional = (cfg.mode == pidpi_pkg::MODE_POSITIONAL);

        err = ERR_W'(setpoint) - ERR_W'(measured);
        de  = (ERR_W+1)'(err) - (ERR_W+1)'(last_err_reg);
        de1 = (ERR_W+1)'(last_err_reg) - (ERR_W+1)'(older_err_reg);
        dd  = (ERR_W+2)'(de) - (ERR_W+2)'(de1);

        // operand select: positional uses e and e - e(k-1)
        kp_op = positional ? (ERR_W+2)'(err) : (ERR_W+2)'(de);
        kd_op = positional ? (ERR_W+2)'(de)  : dd;

        kp_prod = (GW+ERR_W+2)'($signed(cfg.kp) * kp_op);
        ki_prod = (GW+ERR_W)'($signed(cfg.ki) * err);
        kd_prod = (GW+ERR_W+2)'($signed(cfg.kd) * kd_op);

        // clamp: upper bound first, lower bound wins when crossed
        top = ACC_W'($signed(cfg.integral_high)) <<< GAIN_FRAC_BITS;
        bot = ACC_W'($signed(cfg.integral_low)) <<< GAIN_FRAC_BITS;
        int_pre        = ACC_W'(integral_reg) + ACC_W'(ki_prod);
        over_top       = int_pre > top;
        int_hi_clamped = over_top ? top : int_pre;
        under_bot      = int_hi_clamped < bot;
        int_clamped    = under_bot ? bot : int_hi_clamped;

        third_term = positional ? int_clamped : ACC_W'(ki_prod);
        acc        = ACC_W'(kp_prod) + ACC_W'(kd_prod) + third_term;

        shifted = acc >>> GAIN_FRAC_BITS;  // floor
        pos_ovf = !shifted[ACC_W-1] && (|shifted[ACC_W-2:DW-1]);
        neg_ovf = shifted[ACC_W-1] && !(&shifted[ACC_W-2:DW-1]);

        if (pos_ovf) begin
            result.drive = {1'b0, {(DW-1){1'b1}}};
        end else if (neg_ovf) begin
            result.drive = {1'b1, {(DW-1){1'b0}}};
        end else begin
            result.drive = shifted[DW-1:0];
        end
        result.integral_limited = positional && (over_top || under_bot);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg  <= '0;
            older_err_reg <= '0;
            integral_reg  <= '0;
        end else if (upd) begin
            older_err_reg <= last_err_reg;
            last_err_reg  <= err;
            if (positional) begin
                integral_reg <= int_clamped[INT_W-1:0];
            end
        end
    end

endmodule

// ----- design/pid_controller_positional_incremental.sv -----
// ----------------------------------------------------------------------------
// pid_controller_positional_incremental
// Discrete PID controller, positional output with clamped integral or
// incremental output, behind valid/ready input and result channels.
// ----------------------------------------------------------------------------
// Path: an accepted word goes into the input register, then through the
//   one-pass arithmetic into the result register.
// Throughput: one word per cycle unless the result side stalls on m_ready;
//   the integral and error-history feedback closes within that single arithmetic pass.
// Reset: synchronous active-low aresetn clears the error history, integral
//   and both valid flags and loads the configuration reset values.
module pid_controller_positional_incremental #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [pidpi_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [pidpi_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // sample input
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         s_measured,
    input  logic signed [SAMPLE_WIDTH-1:0]         s_setpoint,
    // result output
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pidpi_pkg::DRIVE_W-1:0]   m_drive,
    output logic                                   m_integral_limited
);

    pidpi_pkg::cfg_t    cfg;
    pidpi_pkg::result_t result;

    // input register stage
    logic                           in_vld_reg;
    logic                           in_vld_next;
    logic signed [SAMPLE_WIDTH-1:0] meas_reg;
    logic signed [SAMPLE_WIDTH-1:0] setp_reg;

    // result register stage
    logic                           out_vld_reg;
    logic                           out_vld_next;
    pidpi_pkg::result_t             out_reg;

    logic s_accept;
    logic adv;      // input word moves through the arithmetic into the result

    pidpi_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidpi_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .upd      (adv),
        .measured (meas_reg),
        .setpoint (setp_reg),
        .cfg      (cfg),
        .result   (result)
    );

    // The result register frees whenever its word is taken, so a new word can
    // move in on the same edge; the input register frees on the same terms.
    assign adv      = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready  = !in_vld_reg || adv;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (adv) begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (adv) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            meas_reg <= s_measured;
            setp_reg <= s_setpoint;
        end
        if (adv) begin
            out_reg <= result;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_drive            = out_reg.drive;
    assign m_integral_limited = out_reg.integral_limited;

`ifndef SYNTH
    // a result only appears after a word passed through the arithmetic
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(in_vld_reg))
        else $error("result valid without a word in the input stage");

    // an accepted word always lands in the input stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_vld_reg)
        else $error("accepted word lost");

    // incremental mode never reports a clamped integral
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && cfg.mode == pidpi_pkg::MODE_INCREMENTAL) |=> !m_integral_limited)
        else $error("integral flagged as limited in incremental mode");

    // a held result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready) |=> $stable(out_reg))
        else $error("stalled result changed");
`endif

endmodule

// ----- test/tb_pid_controller_positional_incremental.sv -----
// ----------------------------------------------------------------------------
// tb_pid_controller_positional_incremental
// Self-checking bench for the PID controller. A predictor tracks the error
// history, clamped integral and gain registers and queues the expected drive
// for every accepted sample word. Returned words are compared field by field
// under random idling on both channels, a long result-side hold-off and
// config sweeps covering both modes, extreme gains and crossed limits.
// ----------------------------------------------------------------------------
module tb_pid_controller_positional_incremental;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W      = 16;
    localparam int FRAC_BITS     = 8;
    localparam int PHASE_WORDS   = 50;
    localparam int RANDOM_PHASES = 31;
    localparam int STALL_PHASE   = 2;   // phase that carries the long hold-off
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    localparam longint DRIVE_MAX = (longint'(1) <<< (pidpi_pkg::DRIVE_W - 1)) - 1;
    localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

    typedef logic signed [SAMPLE_W-1:0]          sample_t;
    typedef logic signed [pidpi_pkg::GAIN_W-1:0] gain_t;
    typedef logic signed [pidpi_pkg::LIM_W-1:0]  limit_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {SAMPLE_W-1{1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {SAMPLE_W-1{1'b0}}};
    localparam gain_t   GAIN_MAX   = {1'b0, {pidpi_pkg::GAIN_W-1{1'b1}}};
    localparam gain_t   GAIN_MIN   = {1'b1, {pidpi_pkg::GAIN_W-1{1'b0}}};
    localparam limit_t  LIM_MAX    = {1'b0, {pidpi_pkg::LIM_W-1{1'b1}}};
    localparam limit_t  LIM_MIN    = {1'b1, {pidpi_pkg::LIM_W-1{1'b0}}};

    // Tracks the controller state and holds the drive words still to come back.
    class drive_tracker;
        logic   mode;
        gain_t  kp, ki, kd;
        limit_t lim_hi, lim_lo;
        longint err_z1, err_z2, integ;
        pidpi_pkg::result_t due_q[$];
        int     mismatches;

        function new();
            mode       = pidpi_pkg::MODE_RESET;
            kp         = pidpi_pkg::KP_RESET;
            ki         = pidpi_pkg::KI_RESET;
            kd         = pidpi_pkg::KD_RESET;
            lim_hi     = pidpi_pkg::INTEGRAL_HIGH_RESET;
            lim_lo     = pidpi_pkg::INTEGRAL_LOW_RESET;
            err_z1     = 0;
            err_z2     = 0;
            integ      = 0;
            mismatches = 0;
        endfunction

        function void write_reg(pidpi_pkg::cfg_addr_t idx,
                                logic [pidpi_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                pidpi_pkg::CFG_MODE:          mode   = val[0];
                pidpi_pkg::CFG_KP:            kp     = val[pidpi_pkg::GAIN_W-1:0];
                pidpi_pkg::CFG_KI:            ki     = val[pidpi_pkg::GAIN_W-1:0];
                pidpi_pkg::CFG_KD:            kd     = val[pidpi_pkg::GAIN_W-1:0];
                pidpi_pkg::CFG_INTEGRAL_HIGH: lim_hi = val[pidpi_pkg::LIM_W-1:0];
                pidpi_pkg::CFG_INTEGRAL_LOW:  lim_lo = val[pidpi_pkg::LIM_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_sample(sample_t meas, sample_t setp);
            longint  err, de, de1, acc, top, bot;
            pidpi_pkg::result_t due;
            due.integral_limited = 1'b0;
            err = longint'(setp) - longint'(meas);
            if (mode == pidpi_pkg::MODE_POSITIONAL) begin
                top   = longint'(lim_hi) * (longint'(1) <<< FRAC_BITS);
                bot   = longint'(lim_lo) * (longint'(1) <<< FRAC_BITS);
                integ = integ + longint'(ki) * err;
                // upper clamp first, so a crossed lower limit wins
                if (integ > top) begin
                    integ = top;
                    due.integral_limited = 1'b1;
                end
                if (integ < bot) begin
                    integ = bot;
                    due.integral_limited = 1'b1;
                end
                acc = longint'(kp) * err + integ + longint'(kd) * (err - err_z1);
            end else begin
                de  = err - err_z1;
                de1 = err_z1 - err_z2;
                acc = longint'(kp) * de + longint'(ki) * err + longint'(kd) * (de - de1);
            end
            err_z2 = err_z1;
            err_z1 = err;
            acc = acc >>> FRAC_BITS;
            if (acc > DRIVE_MAX) acc = DRIVE_MAX;
            if (acc < DRIVE_MIN) acc = DRIVE_MIN;
            due.drive = acc[pidpi_pkg::DRIVE_W-1:0];
            due_q.push_back(due);
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX) $display("%0t ns: mismatch, %s", $realtime, what);
        endfunction

        function void check_drive(logic signed [pidpi_pkg::DRIVE_W-1:0] drive, logic limited);
            pidpi_pkg::result_t due;
            if (due_q.size() == 0) begin
                report($sformatf("unexpected word drive=%0d limited=%0b", drive, limited));
                return;
            end
            due = due_q.pop_front();
            if (drive !== due.drive)
                report($sformatf("drive expected %0d got %0d", $signed(due.drive), drive));
            if (limited !== due.integral_limited)
                report($sformatf("integral_limited expected %0b got %0b",
                                 due.integral_limited, limited));
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn            = 1'b0;
    logic                   cfg_wr_en          = 1'b0;
    logic [pidpi_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [pidpi_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                   s_valid            = 1'b0;
    logic                   s_ready;
    sample_t                s_measured         = '0;
    sample_t                s_setpoint         = '0;
    logic                   m_valid;
    logic                   m_ready            = 1'b0;
    logic signed [pidpi_pkg::DRIVE_W-1:0] m_drive;
    logic                   m_integral_limited;

    drive_tracker tracker = new();

    bit full_speed  = 1'b0;  // no idling on either side
    bit hold_rx_req = 1'b0;  // asks the result side for one long hold-off

    pid_controller_positional_incremental #(
        .SAMPLE_WIDTH   (SAMPLE_W),
        .GAIN_FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_measured         (s_measured),
        .s_setpoint         (s_setpoint),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_drive            (m_drive),
        .m_integral_limited (m_integral_limited)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        int cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    // Result side: checks every accepted word, then picks next cycle's ready.
    // Short random stalls, plus one long hold-off on request so the
    // pipeline fills and s_ready drops.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) tracker.check_drive(m_drive, m_integral_limited);
            if (hold_rx_req) begin
                hold_rx_req = 1'b0;
                hold_left   = LONG_HOLD;
            end else if (hold_left == 0 && !full_speed && $urandom_range(0, 99) < 3) begin
                hold_left = $urandom_range(8, 40);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= full_speed || ($urandom_range(0, 99) < 75);
            end
        end
    end

    // mostly back-to-back words, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (full_speed || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic gain_t pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return gain_t'($urandom);
        if (r < 80) return gain_t'($urandom_range(0, 1200) - 600);
        if (r < 90) return ($urandom_range(0, 1) != 0) ? GAIN_MAX : GAIN_MIN;
        return '0;
    endfunction

    function automatic limit_t pick_limit();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return limit_t'($urandom_range(0, 4000) - 2000);
        if (r < 8) return limit_t'($urandom_range(0, 200000) - 100000);
        if (r == 8) return LIM_MIN;
        return LIM_MAX;
    endfunction

    // Leaves the write enable high so back-to-back writes need no toggle.
    task automatic put_reg(pidpi_pkg::cfg_addr_t idx, logic [pidpi_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        tracker.write_reg(idx, val);
    endtask

    task automatic program_cfg(logic mode, gain_t kp, gain_t ki, gain_t kd,
                               limit_t hi, limit_t lo);
        put_reg(pidpi_pkg::CFG_MODE, pidpi_pkg::CFG_DATA_W'(mode));
        put_reg(pidpi_pkg::CFG_KP, pidpi_pkg::CFG_DATA_W'(kp));
        put_reg(pidpi_pkg::CFG_KI, pidpi_pkg::CFG_DATA_W'(ki));
        put_reg(pidpi_pkg::CFG_KD, pidpi_pkg::CFG_DATA_W'(kd));
        put_reg(pidpi_pkg::CFG_INTEGRAL_HIGH, pidpi_pkg::CFG_DATA_W'(hi));
        put_reg(pidpi_pkg::CFG_INTEGRAL_LOW, pidpi_pkg::CFG_DATA_W'(lo));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_cfg();
        limit_t a, b, t;
        a = pick_limit();
        b = pick_limit();
        // crossed limits now and then, otherwise high >= low
        if ($urandom_range(0, 99) < 15) begin
            if (a > b) begin
                t = a; a = b; b = t;
            end
        end else if (a < b) begin
            t = a; a = b; b = t;
        end
        program_cfg(($urandom_range(0, 1) != 0) ? pidpi_pkg::MODE_INCREMENTAL
                                                : pidpi_pkg::MODE_POSITIONAL,
                    pick_gain(), pick_gain(), pick_gain(), a, b);
    endtask

    // Valid stays high between words with no gap; it only drops for a gap.
    task automatic send_sample(sample_t meas, sample_t setp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_measured <= meas;
        s_setpoint <= setp;
        do @(posedge aclk); while (!s_ready);
        tracker.take_sample(meas, setp);
    endtask

    // Equal shares of full-range words and a loop tracking a setpoint with small
    // noise; the rest extremes and zero error.
    task automatic send_random(sample_t centre);
        sample_t meas, setp;
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            meas = sample_t'($urandom);
            setp = sample_t'($urandom);
        end else if (r < 80) begin
            setp = centre;
            meas = centre + sample_t'($urandom_range(0, 600) - 300);
        end else if (r < 90) begin
            meas = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            setp = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
        end else begin
            meas = sample_t'($urandom);
            setp = meas;
        end
        send_sample(meas, setp);
    endtask

    // Sender pause: drop valid and wait for every outstanding word, then
    // let the pipe settle before any config write.
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    initial begin
        int      ph, n;
        sample_t centre;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset gains, positional: full-scale error both ways hits both clamps
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        send_sample('0, '0);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sd5, -16'sd3);
        drain();

        // extreme gains with the widest limits
        program_cfg(pidpi_pkg::MODE_POSITIONAL, GAIN_MAX, GAIN_MAX, GAIN_MIN, LIM_MAX, LIM_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        send_sample('0, '0);
        drain();

        // crossed limits: low above high, the low limit must win
        program_cfg(pidpi_pkg::MODE_POSITIONAL, 16'sd256, 16'sd256, '0, -21'sd100, 21'sd200);
        send_sample('0, 16'sd10);
        send_sample(16'sd10, '0);
        send_sample('0, '0);
        drain();

        // incremental with extreme gains; history carries over from above
        program_cfg(pidpi_pkg::MODE_INCREMENTAL, GAIN_MIN, GAIN_MIN, GAIN_MAX,
                    21'sd1000, -21'sd500);
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        send_sample('0, '0);
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        drain();

        // back to positional: the integral left from earlier must carry over
        program_cfg(pidpi_pkg::MODE_POSITIONAL, '0, 16'sd16, '0, 21'sd50, -21'sd50);
        send_sample('0, 16'sd100);
        send_sample('0, 16'sd100);
        send_sample(-16'sd50, '0);
        drain();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_cfg();
            centre     = sample_t'($urandom_range(0, 40000) - 20000);
            full_speed = (ph == STALL_PHASE) || (ph % 5 == 4);
            // sender keeps offering while the result side sits on its ready
            if (ph == STALL_PHASE) hold_rx_req = 1'b1;
            for (n = 0; n < PHASE_WORDS; n++) send_random(centre);
            drain();
        end
        full_speed = 1'b0;

        repeat (10) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
